/* design/wcre_pkg.sv */
// Shared constants, types and a helper function for the window convolution block.
`default_nettype none
package wcre_pkg;

  localparam int MAX_WIDTH        = 1024;
  localparam int MAX_HEIGHT       = 1024;
  localparam int MAX_RADIUS       = 2;
  localparam int WEIGHT_FRAC_BITS = 15;

  // one raster ring holds every pixel a pending output can still need
  localparam int RING_SIZE  = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
  localparam int ADDR_BITS  = $clog2(RING_SIZE);
  localparam int OFF_BITS   = ADDR_BITS + 2;
  localparam int WID_BITS   = $clog2(MAX_WIDTH + 1);
  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int ROW_BITS   = $clog2(MAX_HEIGHT + 1);
  localparam int LAG_BITS   = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
  localparam int RAD_BITS   = 2;
  localparam int TAP_BITS   = $clog2(MAX_RADIUS + 1) + 1;
  localparam int DIM_BITS   = 11;
  localparam int WT_BITS    = 16;
  localparam int WSET_BITS  = 48;
  localparam int PIX_BITS   = 24;
  localparam int PROD_BITS  = 8 + WT_BITS;
  localparam int NTAPS      = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int ACC_BITS   = PROD_BITS + $clog2(NTAPS);
  localparam int CFG_DATA_BITS = 64;
  localparam int CFG_ADDR_BITS = 6;

  // register indexes
  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_RADIUS = 3'd2;
  localparam logic [2:0] REG_WNEAR  = 3'd3;
  localparam logic [2:0] REG_WFAR   = 3'd4;

  localparam logic KIND_PIXEL = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE, S_STEP, S_TAPS, S_WAIT1, S_WAIT2, S_DONE
  } state_t;

  typedef struct packed {
    logic valid;
    logic clear;
  } mac_ctl_t;

  // weight class from unordered (|dy|,|dx|)
  function automatic logic [WT_BITS-1:0] weight_of(input logic [1:0] a,
                                                   input logic [1:0] b,
                                                   input logic [WSET_BITS-1:0] wn,
                                                   input logic [WSET_BITS-1:0] wf);
    logic [1:0] lo;
    logic [1:0] hi;
    logic [WT_BITS-1:0] w;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (hi <= 2'd1) begin
      case (2'(lo + hi))
        2'd0:    w = wn[15:0];
        2'd1:    w = wn[31:16];
        default: w = wn[47:32];
      endcase
    end else begin
      case (lo)
        2'd0:    w = wf[15:0];
        2'd1:    w = wf[31:16];
        default: w = wf[47:32];
      endcase
    end
    return w;
  endfunction

endpackage
`default_nettype wire

/* design/wcre_if.sv */
// Stream channel interfaces for pixel requests and filtered results.
`default_nettype none
interface wcre_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  modport source (output valid, kind, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, kind, red_in, green_in, blue_in, output ready);
endinterface

interface wcre_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       frame_end;
  modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface
`default_nettype wire

/* design/wcre_ram.sv */
// Simple dual-port RAM, registered read.
`default_nettype none
module wcre_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* design/wcre_mac.sv */
// Three-channel multiply-accumulate with truncation and saturation.
`default_nettype none
module wcre_mac
  import wcre_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire mac_ctl_t            ctl,
  input  wire logic [PIX_BITS-1:0] pix,
  input  wire logic [WT_BITS-1:0]  weight,
  output      logic [7:0]          red,
  output      logic [7:0]          green,
  output      logic [7:0]          blue
);
  logic [PROD_BITS-1:0] prod_r [3];
  logic                 prod_valid_r;
  logic [ACC_BITS-1:0]  acc_r  [3];
  logic [7:0]           sat    [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
    end else begin
      prod_valid_r <= ctl.valid;
    end
    for (int c = 0; c < 3; c++) begin
      prod_r[c] <= PROD_BITS'(pix[8*c +: 8]) * PROD_BITS'(weight);
      if (ctl.clear) begin
        acc_r[c] <= '0;
      end else if (prod_valid_r) begin
        acc_r[c] <= acc_r[c] + ACC_BITS'(prod_r[c]);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if ((acc_r[c] >> WEIGHT_FRAC_BITS) > ACC_BITS'(255)) begin
        sat[c] = 8'hFF;
      end else begin
        sat[c] = acc_r[c][WEIGHT_FRAC_BITS +: 8];
      end
    end
  end

  assign red   = sat[0];
  assign green = sat[1];
  assign blue  = sat[2];
endmodule
`default_nettype wire

/* design/window_convolution_replicate_edge_core.sv */
// Top level: config registers, sequencer and line ring of the window filter.
//
// Usage notes
//  - in_ch carries requests: kind 0 is an RGB pixel in raster order, kind 1 a
//    drain step. out_ch carries filtered pixels, frame_end on the last one.
//  - cfg_* is an APB-style port, 64-bit data, register i at byte 8*i. Write
//    geometry and weights only while the block is idle.
//  - Output k of a frame leaves with request k + r*width + r; drains flush
//    the tail once all pixels are in.
//  - A request with no output passes only the step state; with output it goes on
//    through the tap, wait and done states: the single line ring read port is
//    walked once per tap (1, 9 or 25 reads) feeding a two-stage MAC.
//  - A finished result sits in an output register; the next request is taken
//    while it waits. If the receiver stalls, a second result waits in the
//    done state and input stops.
//  - Reset (synchronous, active low) restores register defaults and ends any
//    frame. The ring has no clearing pass: outputs only read entries the
//    current frame wrote.
`default_nettype none
module window_convolution_replicate_edge_core
  import wcre_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  wcre_in_if.sink                       in_ch,
  wcre_out_if.source                    out_ch,
  input  wire logic                     cfg_psel,
  input  wire logic                     cfg_penable,
  input  wire logic                     cfg_pwrite,
  input  wire logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_pwdata,
  output      logic [CFG_DATA_BITS-1:0] cfg_prdata,
  output      logic                     cfg_pready
);

  // configuration registers
  logic [DIM_BITS-1:0]  cfg_width_r, cfg_height_r;
  logic [RAD_BITS-1:0]  cfg_radius_r;
  logic [WSET_BITS-1:0] cfg_wnear_r, cfg_wfar_r;
  logic                 cfg_wr;
  logic [2:0]           cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= DIM_BITS'(1024);
      cfg_height_r <= DIM_BITS'(1024);
      cfg_radius_r <= RAD_BITS'(1);
      cfg_wnear_r  <= 48'h0E39_0E39_0E39;
      cfg_wfar_r   <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_WIDTH:  cfg_width_r  <= cfg_pwdata[DIM_BITS-1:0];
        REG_HEIGHT: cfg_height_r <= cfg_pwdata[DIM_BITS-1:0];
        REG_RADIUS: cfg_radius_r <= cfg_pwdata[RAD_BITS-1:0];
        REG_WNEAR:  cfg_wnear_r  <= cfg_pwdata[WSET_BITS-1:0];
        REG_WFAR:   cfg_wfar_r   <= cfg_pwdata[WSET_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_WIDTH:  cfg_prdata = CFG_DATA_BITS'(cfg_width_r);
      REG_HEIGHT: cfg_prdata = CFG_DATA_BITS'(cfg_height_r);
      REG_RADIUS: cfg_prdata = CFG_DATA_BITS'(cfg_radius_r);
      REG_WNEAR:  cfg_prdata = CFG_DATA_BITS'(cfg_wnear_r);
      REG_WFAR:   cfg_prdata = CFG_DATA_BITS'(cfg_wfar_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // geometry clamped for latching at frame start
  logic [WID_BITS-1:0] geo_w;
  logic [ROW_BITS-1:0] geo_h;
  logic [RAD_BITS-1:0] geo_r;
  logic [LAG_BITS-1:0] geo_lag;

  always_comb begin
    if (cfg_width_r == '0)                     geo_w = WID_BITS'(1);
    else if (32'(cfg_width_r) > MAX_WIDTH)     geo_w = WID_BITS'(MAX_WIDTH);
    else                                       geo_w = WID_BITS'(cfg_width_r);
    if (cfg_height_r == '0)                    geo_h = ROW_BITS'(1);
    else if (32'(cfg_height_r) > MAX_HEIGHT)   geo_h = ROW_BITS'(MAX_HEIGHT);
    else                                       geo_h = ROW_BITS'(cfg_height_r);
    if (32'(cfg_radius_r) > MAX_RADIUS)        geo_r = RAD_BITS'(MAX_RADIUS);
    else                                       geo_r = cfg_radius_r;
    geo_lag = LAG_BITS'(LAG_BITS'(geo_r) * LAG_BITS'(geo_w) + LAG_BITS'(geo_r));
  end

  // frame state
  state_t              state_r, state_nxt;
  logic                active_r, input_done_r, skip_r;
  logic [WID_BITS-1:0] lat_w_r;
  logic [ROW_BITS-1:0] lat_h_r;
  logic [RAD_BITS-1:0] lat_r_r;
  logic [LAG_BITS-1:0] lag_r, warm_r;
  logic [COL_BITS-1:0] icol_r, ocol_r;
  logic [ROW_BITS-1:0] irow_r, orow_r;
  logic [ADDR_BITS-1:0] wr_addr_r, oc_addr_r;
  logic                kind_r;
  logic [PIX_BITS-1:0] pix_r;

  logic signed [TAP_BITS-1:0] ty_r, tx_r, rad_s;
  logic                       rd_valid_r;
  logic [WT_BITS-1:0]         weight_r;

  logic                out_valid_r, out_end_r;
  logic [7:0]          out_red_r, out_green_r, out_blue_r;

  mac_ctl_t   mac_ctl;
  logic [7:0] mac_red, mac_green, mac_blue;

  logic accept, in_ready, mem_we, issue, to_taps, last_tap, out_load;

  assign rad_s  = TAP_BITS'(lat_r_r);
  assign accept = in_ch.valid && in_ready;
  assign last_tap = (ty_r == rad_s) && (tx_r == rad_s);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    issue     = 1'b0;
    to_taps   = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) state_nxt = S_STEP;
      end
      S_STEP: begin
        if (skip_r || (!input_done_r && kind_r != KIND_PIXEL)) begin
          state_nxt = S_IDLE;
        end else begin
          mem_we = !input_done_r;
          if (warm_r < lag_r) begin
            state_nxt = S_IDLE;
          end else begin
            to_taps   = 1'b1;
            state_nxt = S_TAPS;
          end
        end
      end
      S_TAPS: begin
        issue = 1'b1;
        if (last_tap) state_nxt = S_WAIT1;
      end
      S_WAIT1: state_nxt = S_WAIT2;
      S_WAIT2: state_nxt = S_DONE;
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // tap address with replicated borders
  logic signed [ROW_BITS+1:0] ypos;
  logic signed [WID_BITS+1:0] xpos;
  logic signed [TAP_BITS-1:0] eff_dy, eff_dx;
  logic signed [OFF_BITS-1:0] w_s, off_y, tap_sum;
  logic [ADDR_BITS-1:0]       raddr;
  logic [1:0]                 ady, adx;

  always_comb begin
    ypos = $signed({2'b00, orow_r}) + (ROW_BITS+2)'(ty_r);
    if (ypos < 0)
      eff_dy = TAP_BITS'(-$signed({2'b00, orow_r}));
    else if (ypos >= $signed({2'b00, lat_h_r}))
      eff_dy = TAP_BITS'($signed({2'b00, lat_h_r}) - 1 - $signed({2'b00, orow_r}));
    else
      eff_dy = ty_r;
    xpos = $signed({(WID_BITS+2-COL_BITS)'(0), ocol_r}) + (WID_BITS+2)'(tx_r);
    if (xpos < 0)
      eff_dx = TAP_BITS'(-$signed({(WID_BITS+2-COL_BITS)'(0), ocol_r}));
    else if (xpos >= $signed({2'b00, lat_w_r}))
      eff_dx = TAP_BITS'($signed({2'b00, lat_w_r}) - 1
                         - $signed({(WID_BITS+2-COL_BITS)'(0), ocol_r}));
    else
      eff_dx = tx_r;
    w_s = $signed(OFF_BITS'(lat_w_r));
    case (eff_dy)
      -TAP_BITS'(2): off_y = -(w_s <<< 1);
      -TAP_BITS'(1): off_y = -w_s;
      TAP_BITS'(1):  off_y = w_s;
      TAP_BITS'(2):  off_y = w_s <<< 1;
      default:       off_y = '0;
    endcase
    tap_sum = $signed(OFF_BITS'(oc_addr_r)) + off_y + OFF_BITS'(eff_dx);
    if (tap_sum < 0)
      raddr = ADDR_BITS'(tap_sum + OFF_BITS'(RING_SIZE));
    else if (tap_sum >= $signed(OFF_BITS'(RING_SIZE)))
      raddr = ADDR_BITS'(tap_sum - OFF_BITS'(RING_SIZE));
    else
      raddr = ADDR_BITS'(tap_sum);
    // weight class uses the unclamped offsets
    ady = 2'(ty_r < 0 ? -ty_r : ty_r);
    adx = 2'(tx_r < 0 ? -tx_r : tx_r);
  end

  // raster positions advanced on input write and on output
  logic [COL_BITS-1:0]  icol_nxt, ocol_nxt;
  logic [ROW_BITS-1:0]  irow_nxt, orow_nxt;
  logic [ADDR_BITS-1:0] wr_addr_nxt, oc_addr_nxt;

  always_comb begin
    if (WID_BITS'(icol_r) + WID_BITS'(1) == lat_w_r) begin
      icol_nxt = '0;
      irow_nxt = irow_r + ROW_BITS'(1);
    end else begin
      icol_nxt = icol_r + COL_BITS'(1);
      irow_nxt = irow_r;
    end
    if (WID_BITS'(ocol_r) + WID_BITS'(1) == lat_w_r) begin
      ocol_nxt = '0;
      orow_nxt = orow_r + ROW_BITS'(1);
    end else begin
      ocol_nxt = ocol_r + COL_BITS'(1);
      orow_nxt = orow_r;
    end
    wr_addr_nxt = (32'(wr_addr_r) == RING_SIZE - 1) ? '0 : wr_addr_r + ADDR_BITS'(1);
    oc_addr_nxt = (32'(oc_addr_r) == RING_SIZE - 1) ? '0 : oc_addr_r + ADDR_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      input_done_r <= 1'b0;
      skip_r       <= 1'b0;
      warm_r       <= '0;
      icol_r       <= '0;
      irow_r       <= '0;
      ocol_r       <= '0;
      orow_r       <= '0;
      wr_addr_r    <= '0;
      oc_addr_r    <= '0;
      lat_w_r      <= WID_BITS'(1);
      lat_h_r      <= ROW_BITS'(1);
      lat_r_r      <= '0;
      lag_r        <= '0;
      rd_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      rd_valid_r <= issue;
      if (accept) begin
        kind_r <= in_ch.kind;
        pix_r  <= {in_ch.blue_in, in_ch.green_in, in_ch.red_in};
        skip_r <= !active_r && in_ch.kind != KIND_PIXEL;
        if (!active_r && in_ch.kind == KIND_PIXEL) begin
          // new frame: latch geometry, restart counters
          active_r     <= 1'b1;
          input_done_r <= 1'b0;
          lat_w_r      <= geo_w;
          lat_h_r      <= geo_h;
          lat_r_r      <= geo_r;
          lag_r        <= geo_lag;
          warm_r       <= '0;
          icol_r       <= '0;
          irow_r       <= '0;
          ocol_r       <= '0;
          orow_r       <= '0;
          wr_addr_r    <= '0;
          oc_addr_r    <= '0;
        end
      end
      if (mem_we) begin
        icol_r    <= icol_nxt;
        irow_r    <= irow_nxt;
        wr_addr_r <= wr_addr_nxt;
        if (irow_nxt == lat_h_r) input_done_r <= 1'b1;
      end
      if (state_r == S_STEP && state_nxt == S_IDLE && !skip_r
          && !(!input_done_r && kind_r != KIND_PIXEL)) begin
        warm_r <= warm_r + LAG_BITS'(1);
      end
      if (to_taps) begin
        ty_r <= -rad_s;
        tx_r <= -rad_s;
      end else if (issue) begin
        if (tx_r == rad_s) begin
          tx_r <= -rad_s;
          ty_r <= ty_r + TAP_BITS'(1);
        end else begin
          tx_r <= tx_r + TAP_BITS'(1);
        end
      end
      if (issue) weight_r <= weight_of(ady, adx, cfg_wnear_r, cfg_wfar_r);
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_end_r   <= (orow_nxt == lat_h_r);
        ocol_r      <= ocol_nxt;
        orow_r      <= orow_nxt;
        oc_addr_r   <= oc_addr_nxt;
        if (orow_nxt == lat_h_r) active_r <= 1'b0;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_red_r   <= mac_red;
      out_green_r <= mac_green;
      out_blue_r  <= mac_blue;
    end
  end

  // line ring
  logic [PIX_BITS-1:0] rd_pix;

  wcre_ram #(.DEPTH(RING_SIZE), .WIDTH(PIX_BITS)) u_ring (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_addr_r),
    .wdata (pix_r),
    .raddr (raddr),
    .rdata (rd_pix)
  );

  assign mac_ctl.valid = rd_valid_r;
  assign mac_ctl.clear = to_taps;

  wcre_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .pix    (rd_pix),
    .weight (weight_r),
    .red    (mac_red),
    .green  (mac_green),
    .blue   (mac_blue)
  );

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.red_out   = out_red_r;
  assign out_ch.green_out = out_green_r;
  assign out_ch.blue_out  = out_blue_r;
  assign out_ch.frame_end = out_end_r;

endmodule
`default_nettype wire

/* design/wcre_checker.sv */
// Port-level checks for the window filter, bound to the top level.
`default_nettype none
module wcre_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready
);
  // a result offered stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // reset empties the output register
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result present after reset");

  // one request in flight at a time
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken back to back");
endmodule

bind window_convolution_replicate_edge_core wcre_checker u_wcre_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);
`default_nettype wire
